>>> hw/rtl/ws2812_dimmed_bit_encoder_defines.svh
// Assertion macros used by the LED bit encoder top level.
`ifndef WS2812_DIMMED_BIT_ENCODER_DEFINES_SVH
`define WS2812_DIMMED_BIT_ENCODER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define WDBE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wdbe same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define WDBE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wdbe next-cycle check failed");

`endif

>>> hw/rtl/wdbe_pkg.sv
// Types, constants and gain table for the LED bit encoder.
`default_nettype none
package wdbe_pkg;

  localparam int BITS_PER_LED   = 24;
  localparam int MAX_BRIGHTNESS = 45;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [5:0] BRIGHTNESS_RST  = 6'd45;
  localparam logic [7:0] ONE_DUTY_RST    = 8'd53;
  localparam logic [7:0] ZERO_DUTY_RST   = 8'd27;
  localparam logic [7:0] RESET_SLOTS_RST = 8'd50;

  typedef enum logic [1:0] {
    REG_BRIGHTNESS  = 2'd0,
    REG_ONE_DUTY    = 2'd1,
    REG_ZERO_DUTY   = 2'd2,
    REG_RESET_SLOTS = 2'd3
  } reg_idx_t;

  // round(256 * tan(b degrees)) for b = 0..45
  localparam logic [8:0] GAIN_ROM [0:MAX_BRIGHTNESS] = '{
    9'd0,   9'd4,   9'd9,   9'd13,  9'd18,  9'd22,  9'd27,  9'd31,  9'd36,  9'd41,
    9'd45,  9'd50,  9'd54,  9'd59,  9'd64,  9'd69,  9'd73,  9'd78,  9'd83,  9'd88,
    9'd93,  9'd98,  9'd103, 9'd109, 9'd114, 9'd119, 9'd125, 9'd130, 9'd136, 9'd142,
    9'd148, 9'd154, 9'd160, 9'd166, 9'd173, 9'd179, 9'd186, 9'd193, 9'd200, 9'd207,
    9'd215, 9'd223, 9'd231, 9'd239, 9'd247, 9'd256
  };

  typedef struct packed {
    logic [BITS_PER_LED-1:0] grb;
    logic                    last;
  } led_word_t;

  typedef struct packed {
    logic [7:0] one_duty;
    logic [7:0] zero_duty;
    logic [7:0] reset_slots;
  } duty_cfg_t;

endpackage
`default_nettype wire

>>> hw/rtl/wdbe_front.sv
// Front end: dims one LED color and packs it as a GRB word.
`default_nettype none
module wdbe_front (
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [23:0]       s_tdata,   // red, green, blue
  input  wire logic              s_tlast,   // last_led
  input  wire logic [5:0]        brightness,
  input  wire logic              full,
  output logic                   push,
  output wdbe_pkg::led_word_t    push_word
);
  import wdbe_pkg::*;

  logic [8:0]  gain;
  logic [16:0] prod_r;
  logic [16:0] prod_g;
  logic [16:0] prod_b;

  assign gain   = GAIN_ROM[brightness];
  assign prod_r = {9'd0, s_tdata[7:0]}   * {8'd0, gain};
  assign prod_g = {9'd0, s_tdata[15:8]}  * {8'd0, gain};
  assign prod_b = {9'd0, s_tdata[23:16]} * {8'd0, gain};

  assign s_tready       = !full;
  assign push           = s_tvalid && !full;
  assign push_word.grb  = {prod_g[15:8], prod_r[15:8], prod_b[15:8]};
  assign push_word.last = s_tlast;
endmodule
`default_nettype wire

>>> hw/rtl/wdbe_queue.sv
// Short register queue between the front and back ends.
`default_nettype none
module wdbe_queue #(
  parameter int DEPTH = wdbe_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire wdbe_pkg::led_word_t push_word,
  input  wire logic                pop,
  output logic                     full,
  output logic                     avail,
  output wdbe_pkg::led_word_t      head
);
  import wdbe_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  led_word_t        slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign avail = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/wdbe_back.sv
// Back end: serializes a GRB word into duty words and the frame reset.
`default_nettype none
module wdbe_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire wdbe_pkg::duty_cfg_t cfg,
  input  wire logic                avail,
  input  wire wdbe_pkg::led_word_t head,
  output logic                     pop,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [15:0]              m_tdata,   // duty, repeat_res
  output logic                     m_tlast,   // run_last
  output logic                     m_tuser    // frame_end
);
  import wdbe_pkg::*;

  typedef enum logic {PH_DATA, PH_RESET} phase_t;

  phase_t                  phase;
  logic                    busy;
  logic [BITS_PER_LED-1:0] word;
  logic [4:0]              cnt;
  logic                    last;
  logic                    has_reset;
  logic                    emit;
  logic                    last_bit;
  logic                    finishing;
  logic                    final_bit;

  assign emit      = busy && (!m_tvalid || m_tready);
  assign last_bit  = (cnt == 5'(BITS_PER_LED - 1));
  assign final_bit = last_bit && !has_reset;
  assign finishing = emit && ((phase == PH_RESET) || final_bit);
  assign pop       = avail && (!busy || finishing);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DATA;
      busy      <= 1'b0;
      m_tvalid  <= 1'b0;
      word      <= '0;
      cnt       <= '0;
      last      <= 1'b0;
      has_reset <= 1'b0;
      m_tdata   <= '0;
      m_tlast   <= 1'b0;
      m_tuser   <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
        if (phase == PH_RESET) begin
          m_tdata <= {cfg.reset_slots, 8'd0};
          m_tlast <= 1'b1;
          m_tuser <= 1'b1;
        end else begin
          m_tdata <= {8'd1, word[BITS_PER_LED-1] ? cfg.one_duty : cfg.zero_duty};
          m_tlast <= final_bit;
          m_tuser <= final_bit && last;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        busy      <= 1'b1;
        phase     <= PH_DATA;
        word      <= head.grb;
        cnt       <= '0;
        last      <= head.last;
        has_reset <= head.last && (cfg.reset_slots != 8'd0);
      end else if (emit) begin
        if (finishing) begin
          busy <= 1'b0;
        end
        if (phase == PH_DATA) begin
          word <= {word[BITS_PER_LED-2:0], 1'b0};
          cnt  <= cnt + 1'b1;
          if (last_bit && has_reset) begin
            phase <= PH_RESET;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/ws2812_dimmed_bit_encoder.sv
// Top level of the dimmed GRB LED bit encoder.
//
// Input stream: one LED color per word, s_tdata holds red, green, blue
// (red lowest), s_tlast marks the last LED of the frame.
// Output stream: one bit-slot word per cycle while m_tready is high and
// words are queued; m_tdata holds duty (low byte) and repeat_res (high
// byte), m_tlast marks the final word of an LED, m_tuser the frame's.
// Each LED becomes 24 words, most significant bit of the GRB word first;
// the last LED adds one reset word (duty 0, held reset_slots slots) when
// reset_slots is nonzero.
// The first word of an LED passes the queue slot, the back end's word
// register and the output register. Each LED gives 24 words, 25 for a
// frame's last LED; the serializer loads the next queued LED with no gap.
// A two-entry queue sits between the dimming front end and the
// serializer, so input keeps flowing while output words wait.
// When the receiver stalls, the output word holds and the queue fills;
// s_tready drops only once the queue is full.
// Reset empties the queue and the output and restores the registers to
// brightness 45, one duty 53, zero duty 27, reset slots 50.
`default_nettype none
`include "ws2812_dimmed_bit_encoder_defines.svh"
module ws2812_dimmed_bit_encoder #(
  parameter int QUEUE_DEPTH = wdbe_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // red, green, blue
  input  wire logic        s_tlast,   // last_led
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // duty, repeat_res
  output logic             m_tlast,   // run_last
  output logic             m_tuser    // frame_end
);
  import wdbe_pkg::*;

  logic [5:0] brightness;
  duty_cfg_t  cfg;
  logic       full;
  logic       avail;
  logic       push;
  logic       pop;
  led_word_t  push_word;
  led_word_t  head;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness      <= BRIGHTNESS_RST;
      cfg.one_duty    <= ONE_DUTY_RST;
      cfg.zero_duty   <= ZERO_DUTY_RST;
      cfg.reset_slots <= RESET_SLOTS_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_BRIGHTNESS: begin
          brightness <= (cfg_data[5:0] > 6'(MAX_BRIGHTNESS)) ?
                        6'(MAX_BRIGHTNESS) : cfg_data[5:0];
        end
        REG_ONE_DUTY:    cfg.one_duty    <= cfg_data;
        REG_ZERO_DUTY:   cfg.zero_duty   <= cfg_data;
        REG_RESET_SLOTS: cfg.reset_slots <= cfg_data;
        default: ;
      endcase
    end
  end

  wdbe_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .brightness (brightness),
    .full       (full),
    .push       (push),
    .push_word  (push_word)
  );

  wdbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .full      (full),
    .avail     (avail),
    .head      (head)
  );

  wdbe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .avail    (avail),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  `WDBE_ASSERT_IMP(a_bright_clamped, 1'b1, brightness <= 6'(MAX_BRIGHTNESS))
  `WDBE_ASSERT_IMP(a_frame_end_closes_run, m_tvalid && m_tuser, m_tlast)
  `WDBE_ASSERT_IMP(a_long_hold_is_reset, m_tvalid && (m_tdata[15:8] != 8'd1),
                   (m_tdata[7:0] == 8'd0) && m_tuser && m_tlast)
  `WDBE_ASSERT_IMP(a_full_blocks_input, full, !s_tready)

endmodule
`default_nettype wire
